// ===== rtl/decision_tree_inference_core_macros.svh =====
// assertion macros for the regression tree walker
// used by decision_tree_inference_core; no other dependencies
`ifndef DECISION_TREE_INFERENCE_CORE_MACROS_SVH
`define DECISION_TREE_INFERENCE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define DTI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DTI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define DTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/dti_pkg.sv =====
// types, codes and microcode table for the regression tree walker
// no dependencies; imported by decision_tree_inference_core
package dti_pkg;

    localparam logic [1:0] KIND_NODE = 2'd0;
    localparam logic [1:0] KIND_FEAT = 2'd1;
    localparam logic [1:0] KIND_WALK = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         node_index;
        logic [5:0]         feature_index;
        logic signed [31:0] value;
        logic               leaf_flag;
        logic [7:0]         left_child;
        logic signed [31:0] leaf_mean;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] prediction;
        logic               walk_error;
        logic [4:0]         depth_reached;
    } t_out_word;

    // one node table entry
    typedef struct packed {
        logic [5:0]  split_feature;
        logic [31:0] threshold;
        logic        is_leaf;
        logic [7:0]  left_child;
        logic [31:0] mean;
    } t_node;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_CMP
    } t_step;

    typedef enum logic [1:0] {
        C_ALWAYS,
        C_CLR_DONE,
        C_WALK,
        C_STOP
    } t_cond;

    typedef struct packed {
        logic  busy;
        logic  clr_wr;
        logic  eval;
        logic  cmp;
        t_cond cond;
        t_step jmp_t;
        t_step jmp_f;
    } t_uword;

    // control store: one word per step, jump to jmp_t when cond holds
    function automatic t_uword f_ucode(t_step step);
        t_uword uw;
        uw = '{busy: 1'b1, clr_wr: 1'b0, eval: 1'b0, cmp: 1'b0,
               cond: C_ALWAYS, jmp_t: ST_IDLE, jmp_f: ST_IDLE};
        case (step)
            ST_CLEAR: begin
                uw.clr_wr = 1'b1;
                uw.cond   = C_CLR_DONE;
                uw.jmp_t  = ST_IDLE;
                uw.jmp_f  = ST_CLEAR;
            end
            ST_IDLE: begin
                uw.busy  = 1'b0;
                uw.cond  = C_WALK;
                uw.jmp_t = ST_EVAL;
                uw.jmp_f = ST_IDLE;
            end
            ST_EVAL: begin
                uw.eval  = 1'b1;
                uw.cond  = C_STOP;
                uw.jmp_t = ST_IDLE;
                uw.jmp_f = ST_CMP;
            end
            ST_CMP: begin
                uw.cmp   = 1'b1;
                uw.cond  = C_ALWAYS;
                uw.jmp_t = ST_EVAL;
                uw.jmp_f = ST_EVAL;
            end
            default: begin
                uw.cond  = C_ALWAYS;
                uw.jmp_t = ST_IDLE;
                uw.jmp_f = ST_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

// ===== rtl/decision_tree_inference_core.sv =====
// regression tree walker: node table, feature vector and microcoded walk sequencer
// depends on dti_pkg and decision_tree_inference_core_macros.svh
//
// Usage: one input channel (start/busy) and one result channel (o_valid).
// A word is taken on a rising edge with start high and busy low. Kind 0
// writes a node table entry, kind 1 writes a feature slot; neither gives a
// result. Kind 2 walks the tree from node 0 and gives one result word,
// shown on o_result for exactly one cycle with o_valid high. Each inner node
// takes an EVAL step that reads its feature, then a CMP step that compares
// it with the threshold and reads the chosen child from the node table. A
// walk ends at a leaf, at the depth limit of 16 or when a child index would
// overflow the table; busy drops in the cycle o_valid rises, so the next
// word may follow. After reset the sequencer sweeps all MAX_NODES entries
// (256 by default) of the node table, one entry per cycle, to mark every
// node a leaf with mean zero; busy is high for the whole sweep. The result
// side has no stall: the receiver must take each o_valid word in its cycle.
module decision_tree_inference_core
    import dti_pkg::*;
#(
    parameter int MAX_NODES    = 256,
    parameter int NUM_FEATURES = 64,
    parameter int MAX_DEPTH    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_word o_result
);

`include "decision_tree_inference_core_macros.svh"

    localparam int NAW = $clog2(MAX_NODES);
    localparam int FAW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int DW  = $clog2(MAX_DEPTH + 1);

    t_node       r_node_mem [MAX_NODES];
    logic [31:0] r_feat_mem [NUM_FEATURES];

    t_step       r_step, n_step;
    t_uword      uw;
    logic        cond_hit;

    logic [NAW-1:0] r_clr;
    logic [DW-1:0]  r_depth;
    t_node          r_nd;
    logic [31:0]    r_fd;
    logic           r_fok;
    logic           r_valid;
    t_out_word      r_res;

    logic accept, walk_acc;
    logic node_wr, feat_wr;
    logic node_rd;
    logic [NAW-1:0] node_rd_addr;
    logic [NAW-1:0] node_wr_addr;
    t_node          node_wr_data;
    logic [NAW+7:0] wr_idx_ext, lc_ext;
    logic [FAW+5:0] fw_idx_ext, fr_idx_ext;
    logic           stop, overflow, too_deep, less;
    logic signed [31:0] feat_x;
    logic [DW+4:0]  depth_ext;

    assign accept   = start && !busy;
    assign walk_acc = accept && (i_item.kind == KIND_WALK);

    // index widening so that any table size works with the 8/6-bit fields
    assign wr_idx_ext = (NAW + 8)'(i_item.node_index);
    assign lc_ext     = (NAW + 8)'(r_nd.left_child);
    assign fw_idx_ext = (FAW + 6)'(i_item.feature_index);
    assign fr_idx_ext = (FAW + 6)'(r_nd.split_feature);
    assign depth_ext  = (DW + 5)'(r_depth);

    // output decode of the control word
    always_comb begin
        uw   = f_ucode(r_step);
        busy = uw.busy;
    end

    // stop tests on the node just read
    always_comb begin
        too_deep = (32'(r_depth) >= 32'(MAX_DEPTH));
        overflow = ((32'(r_nd.left_child) + 32'd1) >= 32'(MAX_NODES));
        stop     = r_nd.is_leaf || too_deep || overflow;
        feat_x   = r_fok ? $signed(r_fd) : 32'sd0;
        less     = (feat_x < $signed(r_nd.threshold));
    end

    // next step: conditional jump
    always_comb begin
        case (uw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_CLR_DONE: cond_hit = (r_clr == NAW'(MAX_NODES - 1));
            C_WALK:     cond_hit = walk_acc;
            C_STOP:     cond_hit = stop;
            default:    cond_hit = 1'b1;
        endcase
        n_step = cond_hit ? uw.jmp_t : uw.jmp_f;
    end

    // node table write port: clearing sweep or a node word
    always_comb begin
        feat_wr = accept && (i_item.kind == KIND_FEAT)
                  && (32'(i_item.feature_index) < 32'(NUM_FEATURES));
        if (uw.clr_wr) begin
            node_wr      = 1'b1;
            node_wr_addr = r_clr;
            node_wr_data = '{split_feature: 6'd0, threshold: 32'd0, is_leaf: 1'b1,
                             left_child: 8'd0, mean: 32'd0};
        end else begin
            node_wr      = accept && (i_item.kind == KIND_NODE)
                           && (32'(i_item.node_index) < 32'(MAX_NODES));
            node_wr_addr = wr_idx_ext[NAW-1:0];
            node_wr_data = '{split_feature: i_item.feature_index,
                             threshold:     i_item.value,
                             is_leaf:       i_item.leaf_flag,
                             left_child:    i_item.left_child,
                             mean:          i_item.leaf_mean};
        end
    end

    // node table read port: root on a walk, chosen child after a compare
    always_comb begin
        node_rd = walk_acc || uw.cmp;
        if (uw.cmp) begin
            node_rd_addr = lc_ext[NAW-1:0] + NAW'(!less);
        end else begin
            node_rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_wr) begin
            r_node_mem[node_wr_addr] <= node_wr_data;
        end
        if (node_rd) begin
            r_nd <= r_node_mem[node_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (feat_wr) begin
            r_feat_mem[fw_idx_ext[FAW-1:0]] <= i_item.value;
        end
        if (uw.eval && !stop) begin
            r_fd  <= r_feat_mem[fr_idx_ext[FAW-1:0]];
            r_fok <= (32'(r_nd.split_feature) < 32'(NUM_FEATURES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.eval && stop) begin
            r_res.prediction    <= r_nd.is_leaf ? $signed(r_nd.mean) : 32'sd0;
            r_res.walk_error    <= !r_nd.is_leaf;
            r_res.depth_reached <= depth_ext[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_CLEAR;
            r_clr   <= '0;
            r_depth <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= uw.eval && stop;
            if (uw.clr_wr) begin
                r_clr <= r_clr + NAW'(1);
            end
            if (walk_acc) begin
                r_depth <= '0;
            end else if (uw.cmp) begin
                r_depth <= r_depth + DW'(1);
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    `DTI_ASSERT_NEXT(a_result_after_stop, i_clk, i_rst_n, (r_step == ST_EVAL) && stop, o_valid, "walk stop gave no result")
    `DTI_ASSERT_NOW(a_error_gives_zero, i_clk, i_rst_n, o_valid && o_result.walk_error, o_result.prediction == 32'sd0, "error result with nonzero prediction")
    `DTI_ASSERT_NOW(a_depth_bound, i_clk, i_rst_n, r_step == ST_EVAL, 32'(r_depth) <= 32'(MAX_DEPTH), "walk depth beyond limit")
    `DTI_ASSERT_NEXT(a_walk_starts_at_root, i_clk, i_rst_n, walk_acc, (r_step == ST_EVAL) && (r_depth == '0), "walk did not start at root")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for decision_tree_inference_core: node table, feature and walk words
// depends on dti_pkg and the core; self-checking against an in-bench tree walker
module tb_top
    import dti_pkg::*;
();

    localparam int TABLE_SIZE    = 256;
    localparam int FEATURE_COUNT = 64;
    localparam int DEPTH_LIMIT   = 16;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 40;
    localparam logic [1:0] KIND_NONE = 2'd3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_word  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_word o_result;

    // tree and feature state as the core should hold it
    logic [5:0]         node_feat [TABLE_SIZE];
    logic signed [31:0] node_thr  [TABLE_SIZE];
    bit                 node_leaf [TABLE_SIZE];
    logic [7:0]         node_lc   [TABLE_SIZE];
    logic signed [31:0] node_mean [TABLE_SIZE];
    logic signed [31:0] feat_val  [FEATURE_COUNT];
    bit                 feat_seen [FEATURE_COUNT];

    t_out_word pending_predictions[$];
    int        n_errors = 0;
    int        n_items  = 0;
    int        n_cycles = 0;
    bit        gaps_on  = 1'b1;

    decision_tree_inference_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_predictions.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, o_result);
                n_errors++;
            end else begin
                want = pending_predictions.pop_front();
                if (o_result.prediction !== want.prediction) begin
                    $display("%0t: prediction expected %h actual %h",
                             $time, want.prediction, o_result.prediction);
                    n_errors++;
                end
                if (o_result.walk_error !== want.walk_error) begin
                    $display("%0t: walk_error expected %b actual %b",
                             $time, want.walk_error, o_result.walk_error);
                    n_errors++;
                end
                if (o_result.depth_reached !== want.depth_reached) begin
                    $display("%0t: depth_reached expected %0d actual %0d",
                             $time, want.depth_reached, o_result.depth_reached);
                    n_errors++;
                end
            end
        end
    end

    function automatic void clear_tree_state();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            node_feat[i] = '0;
            node_thr[i]  = '0;
            node_leaf[i] = 1'b1;
            node_lc[i]   = '0;
            node_mean[i] = '0;
        end
        for (int i = 0; i < FEATURE_COUNT; i++) begin
            feat_val[i]  = '0;
            feat_seen[i] = 1'b0;
        end
    endfunction

    // walks the tree from the root; missing names a feature the walk would read unwritten
    function automatic t_out_word walk_tree(output int missing);
        t_out_word          r;
        int                 node;
        int                 depth;
        logic [7:0]         lc;
        logic signed [31:0] x;
        r       = '0;
        node    = 0;
        depth   = 0;
        missing = -1;
        while (1) begin
            if (node_leaf[node]) begin
                r.prediction = node_mean[node];
                break;
            end
            if (depth >= DEPTH_LIMIT) begin
                r.walk_error = 1'b1;
                break;
            end
            lc = node_lc[node];
            if (int'(lc) + 1 >= TABLE_SIZE) begin
                r.walk_error = 1'b1;
                break;
            end
            if (!feat_seen[node_feat[node]]) begin
                missing = int'(node_feat[node]);
                break;
            end
            x     = feat_val[node_feat[node]];
            node  = (x < node_thr[node]) ? int'(lc) : int'(lc) + 1;
            depth = depth + 1;
        end
        r.depth_reached = depth[4:0];
        return r;
    endfunction

    function automatic void apply_word(input t_in_word w);
        int miss;
        case (w.kind)
            KIND_NODE: begin
                node_feat[w.node_index] = w.feature_index;
                node_thr[w.node_index]  = w.value;
                node_leaf[w.node_index] = w.leaf_flag;
                node_lc[w.node_index]   = w.left_child;
                node_mean[w.node_index] = w.leaf_mean;
            end
            KIND_FEAT: begin
                feat_val[w.feature_index]  = w.value;
                feat_seen[w.feature_index] = 1'b1;
            end
            KIND_WALK: pending_predictions.push_back(walk_tree(miss));
            default: ;
        endcase
    endfunction

    // Q16.16 value biased toward extremes and small numbers so compares hit equality
    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return 32'($signed($urandom_range(0, 6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word rand_word();
        t_in_word    w;
        logic [95:0] raw;
        raw         = {$urandom, $urandom, $urandom};
        w           = raw[$bits(t_in_word)-1:0];
        w.value     = rand_q();
        w.leaf_mean = rand_q();
        return w;
    endfunction

    // start stays high across back-to-back words; it is lowered for a gap and by wait_drained
    task automatic send_word(input t_in_word w);
        if (gaps_on && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_word(w);
        if (w.kind != KIND_NONE) n_items++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_predictions.size() != 0);
    endtask

    task automatic write_node(input int idx, input bit leaf, input logic [5:0] f,
                              input logic [31:0] thr, input logic [7:0] lc,
                              input logic [31:0] mean);
        t_in_word w;
        w               = rand_word();
        w.kind          = KIND_NODE;
        w.node_index    = idx[7:0];
        w.feature_index = f;
        w.value         = thr;
        w.leaf_flag     = leaf;
        w.left_child    = lc;
        w.leaf_mean     = mean;
        send_word(w);
    endtask

    task automatic write_feature(input int idx, input logic [31:0] val);
        t_in_word w;
        w               = rand_word();
        w.kind          = KIND_FEAT;
        w.feature_index = idx[5:0];
        w.value         = val;
        send_word(w);
    endtask

    // loads any feature the walk would read before it was ever written
    task automatic run_walk();
        t_in_word w;
        int       miss;
        void'(walk_tree(miss));
        while (miss >= 0) begin
            write_feature(miss, rand_q());
            void'(walk_tree(miss));
        end
        w      = rand_word();
        w.kind = KIND_WALK;
        send_word(w);
    endtask

    task automatic test_empty_tree();
        t_in_word w;
        run_walk();
        w      = rand_word();
        w.kind = KIND_NONE;
        send_word(w);
        run_walk();
    endtask

    task automatic test_depth_limit();
        write_feature(0, 32'h8000_0000);
        for (int k = 0; k < DEPTH_LIMIT; k++)
            write_node(k, 1'b0, 6'd0, 32'h7FFF_FFFF, 8'(k + 1), rand_q());
        write_node(DEPTH_LIMIT, 1'b1, 6'($urandom), $urandom, 8'($urandom), 32'h7FFF_FFFF);
        run_walk();
        // one more inner level goes past the limit
        write_node(DEPTH_LIMIT, 1'b0, 6'd0, 32'h7FFF_FFFF, 8'(DEPTH_LIMIT + 1), 32'h0);
        run_walk();
    endtask

    task automatic test_child_overflow();
        write_node(2, 1'b0, 6'd0, 32'h7FFF_FFFF, 8'hFF, rand_q());
        run_walk();
    endtask

    task automatic test_split_compare();
        write_node(0, 1'b0, 6'd1, 32'h0, 8'd254, rand_q());
        write_node(254, 1'b1, 6'($urandom), $urandom, 8'($urandom), 32'h7FFF_FFFF);
        write_node(255, 1'b1, 6'($urandom), $urandom, 8'($urandom), 32'h8000_0000);
        write_feature(1, 32'hFFFF_FFFF);
        run_walk();
        // equal goes right
        write_feature(1, 32'h0);
        run_walk();
        write_feature(1, 32'h7FFF_FFFF);
        run_walk();
    endtask

    // breadth-first random tree from the root; sometimes a long left chain
    task automatic build_tree();
        int         open_nodes[$];
        int         open_depth[$];
        bit         open_grow[$];
        int         n, d, nxt, cap, chain_len, lc;
        bit         chain, grow;
        logic [5:0] chain_feat;
        chain      = ($urandom_range(0, 7) == 0);
        chain_len  = $urandom_range(14, 18);
        chain_feat = 6'($urandom);
        cap        = chain ? 64 : $urandom_range(3, 40);
        nxt        = 1;
        open_nodes.push_back(0);
        open_depth.push_back(0);
        open_grow.push_back(1'b1);
        while (open_nodes.size() != 0) begin
            n    = open_nodes.pop_front();
            d    = open_depth.pop_front();
            grow = open_grow.pop_front();
            if (!grow || nxt + 2 > cap ||
                (chain ? d >= chain_len : (d > 0 && $urandom_range(0, 2) == 0))) begin
                write_node(n, 1'b1, 6'($urandom), rand_q(), 8'($urandom), rand_q());
            end else if (!chain && $urandom_range(0, 19) == 0) begin
                write_node(n, 1'b0, 6'($urandom), rand_q(), 8'hFF, rand_q());
            end else begin
                lc  = nxt;
                nxt = nxt + 2;
                if (chain)
                    write_node(n, 1'b0, chain_feat, 32'($urandom_range(0, 1000)),
                               8'(lc), rand_q());
                else
                    write_node(n, 1'b0, 6'($urandom), rand_q(), 8'(lc), rand_q());
                open_nodes.push_back(lc);
                open_depth.push_back(d + 1);
                open_grow.push_back(1'b1);
                open_nodes.push_back(lc + 1);
                open_depth.push_back(d + 1);
                open_grow.push_back(!chain);
            end
        end
        if (chain) write_feature(int'(chain_feat), 32'h8000_0000);
    endtask

    task automatic send_noise();
        t_in_word w;
        repeat ($urandom_range(1, 6)) begin
            w      = rand_word();
            w.kind = 2'($urandom_range(0, 3));
            if (w.kind == KIND_WALK) run_walk();
            else send_word(w);
        end
    endtask

    task automatic test_random_trees();
        int base;
        base = n_items;
        while (n_items - base < RANDOM_ITEMS) begin
            // long stretch with no gaps in the middle of the run
            gaps_on = !((n_items - base) >= 400 && (n_items - base) < 700);
            if ($urandom_range(0, 4) != 0) build_tree();
            else send_noise();
            repeat ($urandom_range(1, 6)) begin
                repeat ($urandom_range(0, 2))
                    write_feature($urandom_range(0, FEATURE_COUNT - 1), rand_q());
                run_walk();
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
    endtask

    initial begin
        clear_tree_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_tree();
        test_depth_limit();
        test_child_overflow();
        test_split_compare();
        wait_drained();
        test_random_trees();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
